FILE: src/tdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types and constants for the triangle depth clipper.
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic signed [31:0] NEAR_RESET = 32'sd65536;
  localparam logic signed [31:0] FAR_RESET  = 32'sd65536000;

  // configuration register indexes
  localparam logic REG_NEAR = 1'b0;
  localparam logic REG_FAR  = 1'b1;

  // number of vertices inside the depth slab
  localparam logic [1:0] KIND_ONE   = 2'd1;
  localparam logic [1:0] KIND_TWO   = 2'd2;
  localparam logic [1:0] KIND_THREE = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vtx_t;

  // one plane crossing: outside vertex, deltas toward the inside vertex
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] plane;
    logic [32:0]        den;
  } xing_t;

  typedef struct packed {
    logic [1:0] kind;
    vtx_t       in0;
    vtx_t       in1;
    vtx_t       in2;
    xing_t      xa;
    xing_t      xb;
  } tri_t;

  typedef struct packed {
    logic [1:0] kind;
    vtx_t       in0;
    vtx_t       in1;
    vtx_t       in2;
    vtx_t       ca;
    vtx_t       cb;
  } res_t;

endpackage

FILE: src/tdc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_classify
// Inside test, vertex ordering and crossing setup; one register stage.
// ----------------------------------------------------------------------------
module tdc_classify (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  tdc_pkg::vtx_t       va,
  input  tdc_pkg::vtx_t       vb,
  input  tdc_pkg::vtx_t       vc,
  input  logic signed [31:0]  near_plane,
  input  logic signed [31:0]  far_plane,
  output logic                valid,
  output tdc_pkg::tri_t       data,
  output logic [33:0]         rem_a,
  output logic [33:0]         rem_b
);

  tdc_pkg::vtx_t  v [3];
  logic [2:0]     in_slab;
  logic [1:0]     ni, no, i0, i1, o0, o1;
  tdc_pkg::xing_t xa, xb;
  logic [32:0]    num_a, num_b;

  function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? (~d + 33'd1) : d;
  endfunction

  function automatic tdc_pkg::xing_t setup(input tdc_pkg::vtx_t o, input tdc_pkg::vtx_t i,
                                           input logic signed [31:0] nr,
                                           input logic signed [31:0] fr);
    tdc_pkg::xing_t r;
    r.ox    = o.x;
    r.oy    = o.y;
    r.dx    = {i.x[31], i.x} - {o.x[31], o.x};
    r.dy    = {i.y[31], i.y} - {o.y[31], o.y};
    r.plane = (o.z < nr) ? nr : fr;
    r.den   = absdiff(i.z, o.z);
    return r;
  endfunction

  always_comb begin
    v[0] = va;
    v[1] = vb;
    v[2] = vc;
    ni = 2'd0;
    no = 2'd0;
    i0 = 2'd0;
    i1 = 2'd0;
    o0 = 2'd0;
    o1 = 2'd0;
    for (int k = 0; k < 3; k++) begin
      in_slab[k] = (v[k].z >= near_plane) && (v[k].z <= far_plane);
      if (in_slab[k]) begin
        if (ni == 2'd0) i0 = 2'(k);
        else if (ni == 2'd1) i1 = 2'(k);
        ni = ni + 2'd1;
      end else begin
        if (no == 2'd0) o0 = 2'(k);
        else o1 = 2'(k);
        no = no + 2'd1;
      end
    end
    xa = setup(v[o0], v[i0], near_plane, far_plane);
    // one inside: second outside vertex; two inside: second inside vertex
    if (ni == tdc_pkg::KIND_ONE) xb = setup(v[o1], v[i0], near_plane, far_plane);
    else xb = setup(v[o0], v[i1], near_plane, far_plane);
    num_a = absdiff(xa.plane, v[o0].z);
    num_b = absdiff(xb.plane, (ni == tdc_pkg::KIND_ONE) ? v[o1].z : v[o0].z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid && (ni != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data.kind <= ni;
      data.in0  <= v[i0];
      data.in1  <= v[i1];
      data.in2  <= v[2];
      data.xa   <= xa;
      data.xb   <= xb;
      rem_a     <= {1'b0, num_a};
      rem_b     <= {1'b0, num_b};
    end
  end

endmodule

FILE: src/tdc_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_div_step
// One restoring division step for both crossing fractions, registered.
// ----------------------------------------------------------------------------
module tdc_div_step #(
  parameter int FRAC_BITS = tdc_pkg::FRAC_BITS_DEF,
  parameter bit FIRST     = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 valid_in,
  input  tdc_pkg::tri_t        data_in,
  input  logic [33:0]          rem_a_in,
  input  logic [33:0]          rem_b_in,
  input  logic [FRAC_BITS:0]   q_a_in,
  input  logic [FRAC_BITS:0]   q_b_in,
  output logic                 valid,
  output tdc_pkg::tri_t        data,
  output logic [33:0]          rem_a,
  output logic [33:0]          rem_b,
  output logic [FRAC_BITS:0]   q_a,
  output logic [FRAC_BITS:0]   q_b
);

  logic [33:0] sh_a, sh_b;
  logic        ge_a, ge_b;

  // the first step tests the unshifted numerator for a fraction of exactly one
  assign sh_a = FIRST ? rem_a_in : {rem_a_in[32:0], 1'b0};
  assign sh_b = FIRST ? rem_b_in : {rem_b_in[32:0], 1'b0};
  assign ge_a = sh_a >= {1'b0, data_in.xa.den};
  assign ge_b = sh_b >= {1'b0, data_in.xb.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data  <= data_in;
      rem_a <= ge_a ? sh_a - {1'b0, data_in.xa.den} : sh_a;
      rem_b <= ge_b ? sh_b - {1'b0, data_in.xb.den} : sh_b;
      q_a   <= {q_a_in[FRAC_BITS-1:0], ge_a};
      q_b   <= {q_b_in[FRAC_BITS-1:0], ge_b};
    end
  end

endmodule

FILE: src/tdc_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_interp
// Crossing coordinates: multiply by the fraction, then floor, add, saturate.
// ----------------------------------------------------------------------------
module tdc_interp #(
  parameter int FRAC_BITS = tdc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                valid_in,
  input  tdc_pkg::tri_t       data_in,
  input  logic [FRAC_BITS:0]  t_a,
  input  logic [FRAC_BITS:0]  t_b,
  output logic                valid,
  output tdc_pkg::res_t       data
);

  localparam int PW = 35 + FRAC_BITS;

  logic                     m_valid;
  tdc_pkg::tri_t            m_data;
  logic signed [PW-1:0]     prod [4];
  logic signed [32:0]       dl   [4];
  logic [FRAC_BITS:0]       tl   [4];
  logic signed [31:0]       res  [4];
  logic [FRAC_BITS:0]       ta, tb;

  // equal depths give a zero fraction
  assign ta = (data_in.xa.den == 33'd0) ? '0 : t_a;
  assign tb = (data_in.xb.den == 33'd0) ? '0 : t_b;

  assign dl[0] = data_in.xa.dx;
  assign dl[1] = data_in.xa.dy;
  assign dl[2] = data_in.xb.dx;
  assign dl[3] = data_in.xb.dy;
  assign tl[0] = ta;
  assign tl[1] = ta;
  assign tl[2] = tb;
  assign tl[3] = tb;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      valid   <= 1'b0;
    end else if (adv) begin
      m_valid <= valid_in;
      valid   <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_data <= data_in;
      for (int k = 0; k < 4; k++) begin
        prod[k] <= PW'(dl[k] * $signed({1'b0, tl[k]}));
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] q;
    logic signed [31:0]   o;
    logic signed [34:0]   s;
    for (int k = 0; k < 4; k++) begin
      q = prod[k] >>> FRAC_BITS;
      case (k)
        0:       o = m_data.xa.ox;
        1:       o = m_data.xa.oy;
        2:       o = m_data.xb.ox;
        default: o = m_data.xb.oy;
      endcase
      s = {{3{o[31]}}, o} + q[34:0];
      if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) res[k] = s[31:0];
      else if (s[34]) res[k] = 32'sh80000000;
      else res[k] = 32'sh7fffffff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data.kind <= m_data.kind;
      data.in0  <= m_data.in0;
      data.in1  <= m_data.in1;
      data.in2  <= m_data.in2;
      data.ca   <= '{x: res[0], y: res[1], z: m_data.xa.plane};
      data.cb   <= '{x: res[2], y: res[3], z: m_data.xb.plane};
    end
  end

endmodule

FILE: src/tdc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_out
// Output register; splits a two-inside result into two transactions.
// ----------------------------------------------------------------------------
module tdc_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  tdc_pkg::res_t  data_in,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_ready,
  output tdc_pkg::vtx_t  vp,
  output tdc_pkg::vtx_t  vq,
  output tdc_pkg::vtx_t  vr,
  output logic           last_piece
);

  tdc_pkg::res_t hold;
  logic          piece;

  assign last_piece = (hold.kind != tdc_pkg::KIND_TWO) || piece;
  // the pipeline moves when the held result is gone or leaves this cycle
  assign adv = !out_valid || (out_ready && last_piece);

  always_comb begin
    case (hold.kind)
      tdc_pkg::KIND_THREE: begin
        vp = hold.in0; vq = hold.in1; vr = hold.in2;
      end
      tdc_pkg::KIND_TWO: begin
        if (piece) begin
          vp = hold.in1; vq = hold.cb; vr = hold.ca;
        end else begin
          vp = hold.in0; vq = hold.in1; vr = hold.ca;
        end
      end
      default: begin
        vp = hold.in0; vq = hold.ca; vr = hold.cb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      piece     <= 1'b0;
    end else if (adv) begin
      out_valid <= valid_in;
      piece     <= 1'b0;
    end else if (out_ready) begin
      piece <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) hold <= data_in;
  end

  a_first_piece: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_piece |-> hold.kind == tdc_pkg::KIND_TWO && !piece)
    else $error("non-final piece outside a two-triangle result");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_piece |=> out_valid && last_piece)
    else $error("second triangle did not follow the first");

  a_kind_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hold.kind != 2'd0)
    else $error("held result with no inside vertex");

endmodule

FILE: src/triangle_depth_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_depth_clip
// Near/far depth clipping of Q16.16 triangles, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle while the output is not stalled; a triangle
// with two inside vertices gives two results and holds the output register for both.
// The crossing fraction comes from a FRAC_BITS + 1 stage restoring divider.
// Reset: clears all valid bits and loads the near and far planes to defaults.
module triangle_depth_clip #(
  parameter int FRAC_BITS = tdc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] c_x,
  input  logic signed [31:0] c_y,
  input  logic signed [31:0] c_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] p_x,
  output logic signed [31:0] p_y,
  output logic signed [31:0] p_z,
  output logic signed [31:0] q_x,
  output logic signed [31:0] q_y,
  output logic signed [31:0] q_z,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic               last_piece
);

  localparam int NS = FRAC_BITS + 1;

  logic signed [31:0] near_plane, far_plane;
  logic               adv;

  logic               dv  [NS+1];
  tdc_pkg::tri_t      dd  [NS+1];
  logic [33:0]        ra  [NS+1];
  logic [33:0]        rb  [NS+1];
  logic [FRAC_BITS:0] qa  [NS+1];
  logic [FRAC_BITS:0] qb  [NS+1];

  logic               iv;
  tdc_pkg::res_t      id;
  tdc_pkg::vtx_t      vp, vq, vr;

  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_plane <= tdc_pkg::NEAR_RESET;
      far_plane  <= tdc_pkg::FAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tdc_pkg::REG_NEAR: near_plane <= cfg_data;
        default:           far_plane  <= cfg_data;
      endcase
    end
  end

  tdc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .va         ('{x: a_x, y: a_y, z: a_z}),
    .vb         ('{x: b_x, y: b_y, z: b_z}),
    .vc         ('{x: c_x, y: c_y, z: c_z}),
    .near_plane (near_plane),
    .far_plane  (far_plane),
    .valid      (dv[0]),
    .data       (dd[0]),
    .rem_a      (ra[0]),
    .rem_b      (rb[0])
  );

  assign qa[0] = '0;
  assign qb[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_div
    tdc_div_step #(
      .FRAC_BITS (FRAC_BITS),
      .FIRST     (k == 0)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .valid_in (dv[k]),
      .data_in  (dd[k]),
      .rem_a_in (ra[k]),
      .rem_b_in (rb[k]),
      .q_a_in   (qa[k]),
      .q_b_in   (qb[k]),
      .valid    (dv[k+1]),
      .data     (dd[k+1]),
      .rem_a    (ra[k+1]),
      .rem_b    (rb[k+1]),
      .q_a      (qa[k+1]),
      .q_b      (qb[k+1])
    );
  end

  tdc_interp #(.FRAC_BITS (FRAC_BITS)) u_interp (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .valid_in (dv[NS]),
    .data_in  (dd[NS]),
    .t_a      (qa[NS]),
    .t_b      (qb[NS]),
    .valid    (iv),
    .data     (id)
  );

  tdc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (iv),
    .data_in    (id),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .vp         (vp),
    .vq         (vq),
    .vr         (vr),
    .last_piece (last_piece)
  );

  assign p_x = vp.x;
  assign p_y = vp.y;
  assign p_z = vp.z;
  assign q_x = vq.x;
  assign q_y = vq.y;
  assign q_z = vq.z;
  assign r_x = vr.x;
  assign r_y = vr.y;
  assign r_z = vr.z;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle depth clipper: directed and random
// triangles across several near/far plane settings, results checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int FB = tdc_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = FB + 5;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] f[9];
    logic               last;
  } piece_t;

  typedef struct {
    logic signed [31:0] v[9];
    bit                 has_exp;
    logic signed [31:0] e[9];
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = tdc_pkg::REG_NEAR;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] vin[9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z;
  logic last_piece;

  string fld_name[9] = '{"p_x", "p_y", "p_z", "q_x", "q_y", "q_z", "r_x", "r_y", "r_z"};

  logic signed [63:0] near_pl, far_pl;
  piece_t pending[$];
  int errors = 0;
  int tri_count = 0;
  int piece_count = 0;
  longint cycles = 0;
  bit calm = 1'b0;

  initial foreach (vin[i]) vin[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_depth_clip #(.FRAC_BITS(FB)) dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .a_x(vin[0]), .a_y(vin[1]), .a_z(vin[2]), .b_x(vin[3]), .b_y(vin[4]),
    .b_z(vin[5]), .c_x(vin[6]), .c_y(vin[7]), .c_z(vin[8]),
    .out_valid, .out_ready, .p_x, .p_y, .p_z, .q_x, .q_y, .q_z, .r_x, .r_y,
    .r_z, .last_piece
  );

  function automatic logic signed [31:0] lerp_sat(logic signed [63:0] o,
                                                  logic signed [63:0] i,
                                                  logic [63:0] t);
    logic signed [127:0] prod;
    logic signed [127:0] sum;
    prod = 128'(i - o) * $signed({64'd0, t});
    sum = o + (prod >>> FB);
    if (sum > 128'sd2147483647) return 32'sh7fffffff;
    if (sum < -128'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  function automatic void plane_cross(logic signed [63:0] o[3],
                                      logic signed [63:0] i[3],
                                      output logic signed [31:0] c[3]);
    logic signed [63:0] pl, num, den;
    logic [63:0] t;
    pl = (o[2] < near_pl) ? near_pl : far_pl;
    num = (pl >= o[2]) ? pl - o[2] : o[2] - pl;
    den = (i[2] >= o[2]) ? i[2] - o[2] : o[2] - i[2];
    t = (den != 0) ? (64'(num) << FB) / 64'(den) : 0;
    if (t > (64'd1 << FB)) t = 64'd1 << FB;
    c[0] = lerp_sat(o[0], i[0], t);
    c[1] = lerp_sat(o[1], i[1], t);
    c[2] = pl[31:0];
  endfunction

  function automatic void push_piece(logic signed [31:0] a[3], logic signed [31:0] b[3],
                                     logic signed [31:0] c[3], logic last);
    piece_t pc;
    for (int k = 0; k < 3; k++) begin
      pc.f[k] = a[k];
      pc.f[3 + k] = b[k];
      pc.f[6 + k] = c[k];
    end
    pc.last = last;
    pending.push_back(pc);
  endfunction

  // Work out the clipped triangles for one input and queue them.
  function automatic void clip_triangle(logic signed [31:0] v[9]);
    logic signed [63:0] w[3][3];
    logic signed [31:0] n[3][3];
    logic signed [31:0] c0[3], c1[3];
    int ins[3], outs[3];
    int ni, no;
    ni = 0;
    no = 0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        w[k][j] = v[3 * k + j];
        n[k][j] = v[3 * k + j];
      end
      if (w[k][2] >= near_pl && w[k][2] <= far_pl) ins[ni++] = k;
      else outs[no++] = k;
    end
    if (ni == 3) begin
      push_piece(n[0], n[1], n[2], 1'b1);
    end else if (ni == 1) begin
      plane_cross(w[outs[0]], w[ins[0]], c0);
      plane_cross(w[outs[1]], w[ins[0]], c1);
      push_piece(n[ins[0]], c0, c1, 1'b1);
    end else if (ni == 2) begin
      plane_cross(w[outs[0]], w[ins[0]], c0);
      plane_cross(w[outs[0]], w[ins[1]], c1);
      push_piece(n[ins[0]], n[ins[1]], c0, 1'b0);
      push_piece(n[ins[1]], c1, c0, 1'b1);
    end
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 22);
  endfunction

  // Output side: random stalls, compare every accepted transaction.
  always @(posedge clk) begin
    piece_t pc;
    logic signed [31:0] got[9];
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      got = '{p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z};
      if (pending.size() == 0) begin
        $error("unexpected result p=(%0d,%0d,%0d)", p_x, p_y, p_z);
        errors++;
      end else begin
        pc = pending.pop_front();
        piece_count++;
        foreach (got[k])
          if (got[k] !== pc.f[k]) begin
            $error("%s: expected %0d, actual %0d", fld_name[k], pc.f[k], got[k]);
            errors++;
          end
        if (last_piece !== pc.last) begin
          $error("last_piece: expected %0b, actual %0b", pc.last, last_piece);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) out_ready <= rst ? 1'b0 : !idle_now();

  always @(posedge clk)
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end

  // Hold valid after a transaction; drop it only while idling.
  task automatic send_triangle(logic signed [31:0] v[9]);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    vin = v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    clip_triangle(v);
    tri_count++;
    @(negedge clk);
  endtask

  task automatic write_plane(logic idx, logic signed [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    if (idx == tdc_pkg::REG_NEAR) near_pl = val;
    else far_pl = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  // Depth biased to fall around the current planes.
  function automatic logic signed [31:0] rnd_depth();
    logic signed [63:0] d;
    case ($urandom_range(5))
      0: return $urandom();
      1: d = near_pl;
      2: d = far_pl;
      default: begin
        d = near_pl + ($signed(64'($urandom())) % (far_pl - near_pl + 64'sd2000000 + 1))
            - 64'sd1000000;
      end
    endcase
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d[31:0];
  endfunction

  initial begin
    localparam logic signed [31:0] MX = 32'sh7fffffff;
    localparam logic signed [31:0] MN = 32'sh80000000;
    localparam logic signed [31:0] ONE = 32'sd65536;
    logic signed [31:0] v[9];
    logic signed [31:0] settings[5][2];
    row_t rows[$];
    row_t rw;
    piece_t pc;

    near_pl = tdc_pkg::NEAR_RESET;
    far_pl = tdc_pkg::FAR_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all inside: passes unchanged, extremes of x and y
    rows.push_back('{'{MX, MN, ONE, MN, MX, 32'sd65536000, 0, 0, 32'sd100000},
                     1, '{MX, MN, ONE, MN, MX, 32'sd65536000, 0, 0, 32'sd100000}});
    rows.push_back('{'{-1, -1, ONE, 1, 1, ONE, 5, 5, ONE}, 1,
                     '{-1, -1, ONE, 1, 1, ONE, 5, 5, ONE}});
    // none inside: no result
    rows.push_back('{'{1, 2, MN, 3, 4, MX, 5, 6, 0}, 0, '{9{32'sd0}}});
    rows.push_back('{'{MX, MX, MX, MN, MN, MX, 0, 0, MX}, 0, '{9{32'sd0}}});
    // one inside, near and far crossings, saturation
    rows.push_back('{'{0, 0, 0, 100, 100, 2 * ONE, 0, 0, 32'sd70000000}, 0, '{9{32'sd0}}});
    rows.push_back('{'{MN, MX, MN, MX, MN, ONE, MN, MX, MX}, 0, '{9{32'sd0}}});
    rows.push_back('{'{5, 5, 2 * ONE, MX, MN, MN, MN, MX, MX}, 0, '{9{32'sd0}}});
    // two inside, each position of the outside vertex
    rows.push_back('{'{0, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 0, 3 * ONE}, 0, '{9{32'sd0}}});
    rows.push_back('{'{ONE, ONE, 2 * ONE, -ONE, ONE, MX, 0, 0, 3 * ONE}, 0, '{9{32'sd0}}});
    rows.push_back('{'{MX, MX, 2 * ONE, MN, MN, 3 * ONE, MN, MX, MN}, 0, '{9{32'sd0}}});
    rows.push_back('{'{1, -1, 32'sd65535, 7, 9, ONE, 3, 3, 32'sd65536000}, 0, '{9{32'sd0}}});
    rows.push_back('{'{1, -1, 32'sd65536001, 7, 9, 32'sd65536000, 3, 3, ONE}, 0,
                     '{9{32'sd0}}});
    foreach (rows[i]) begin
      send_triangle(rows[i].v);
      if (rows[i].has_exp) begin
        pc = pending[pending.size() - 1];
        foreach (pc.f[k])
          if (pc.f[k] !== rows[i].e[k]) begin
            $error("directed row %0d %s: expected %0d, actual %0d",
                   i, fld_name[k], rows[i].e[k], pc.f[k]);
            errors++;
          end
      end
    end
    drain();

    settings = '{'{MN, MX}, '{0, 0}, '{-32'sd5000000, 32'sd5000000},
                 '{ONE, 32'sd65536000}, '{32'sd1000, -32'sd1000}};
    foreach (settings[s]) begin
      write_plane(tdc_pkg::REG_NEAR, settings[s][0]);
      write_plane(tdc_pkg::REG_FAR, settings[s][1]);
      cfg_we <= 1'b0;
      for (int n = 0; n < 300; n++) begin
        calm = (s == 2) && (n >= 100) && (n < 200);
        foreach (v[k]) v[k] = (k % 3 == 2) ? rnd_depth() : rnd_coord();
        send_triangle(v);
      end
      calm = 1'b0;
      drain();
    end

    $display("Sent %0d triangles over %0d plane settings; checked %0d clipped pieces.",
             tri_count, 6, piece_count);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
